// File: rtl/gfcd_pkg.sv
// Package for the gated frequency counter display: widths, reset values,
// the seven-segment font and the BCD digit types.
// No dependencies.
package gfcd_pkg;

   localparam int DISPLAY_DIGITS_DEFAULT = 8;
   localparam int VALUE_DIGITS           = 5;
   localparam int COUNT_WIDTH            = 16;
   localparam int SCAN_WIDTH             = 3;
   localparam int CSR_ADDR_WIDTH         = 3;
   localparam int CSR_DATA_WIDTH         = 32;

   localparam logic [COUNT_WIDTH-1:0] GATE_TICKS_RESET = 16'd1000;
   localparam logic [7:0]             DASH_PATTERN     = 8'hbf;

   // register word index decoded from paddr[2]
   localparam logic REG_GATE_TICKS = 1'b0;

   typedef logic [3:0] bcd_digit_type;
   typedef bcd_digit_type [VALUE_DIGITS-1:0] bcd_value_type;

   // active-low segments, point off
   function automatic logic [7:0] seg_font(input bcd_digit_type digit);
      logic [7:0] pattern;
      case (digit)
         4'd0:    pattern = 8'hc0;
         4'd1:    pattern = 8'hf9;
         4'd2:    pattern = 8'ha4;
         4'd3:    pattern = 8'hb0;
         4'd4:    pattern = 8'h99;
         4'd5:    pattern = 8'h92;
         4'd6:    pattern = 8'h82;
         4'd7:    pattern = 8'hf8;
         4'd8:    pattern = 8'h80;
         4'd9:    pattern = 8'h90;
         default: pattern = DASH_PATTERN;
      endcase
      return pattern;
   endfunction

endpackage

// File: rtl/gated_frequency_counter_display_top.sv
// Gated frequency counter with a multiplexed seven-segment display driver.
// A result is in the output register in the cycle after its tick transfer.
// Throughput: one input transfer per cycle; the output register only stalls input
// when it holds a result the sink has not taken.
// Reset (synchronous): counters cleared, display digits 1,2,3,4,5, scan at position 0,
// gate length 1000 ticks.
module gated_frequency_counter_display_top #(
   parameter int DISPLAY_DIGITS = gfcd_pkg::DISPLAY_DIGITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [0] pulse, [1] tick
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,   // [7:0] segment_pattern,
                                                             // [15:8] digit_enable,
                                                             // [31:16] frequency
   output logic [0:0]                           rsp_tuser,   // [0] reading_done
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gfcd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [gfcd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [gfcd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import gfcd_pkg::*;

   localparam logic [SCAN_WIDTH-1:0] SCAN_LAST = SCAN_WIDTH'(DISPLAY_DIGITS - 1);

   logic [COUNT_WIDTH-1:0] gate_ticks_ff;
   logic [COUNT_WIDTH-1:0] pulse_count_ff, pulse_count_in;
   bcd_value_type          pulse_bcd_ff, pulse_bcd_in;   // decimal mirror, units at [0]
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   bcd_value_type          digit_values_ff, digit_values_in;  // most significant at [0]
   logic [SCAN_WIDTH-1:0]  scan_position_ff, scan_position_in;
   logic [COUNT_WIDTH-1:0] last_frequency_ff, last_frequency_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             segment_pattern_ff, segment_pattern_in;
   logic [7:0]             digit_enable_ff, digit_enable_in;
   logic [COUNT_WIDTH-1:0] frequency_ff;
   logic                   reading_done_ff, reading_done_in;

   logic                   req_accept;
   logic                   pulse;
   logic                   tick;
   logic                   gate_end;
   logic                   carry;
   logic [COUNT_WIDTH-1:0] tick_count_inc;
   logic                   csr_write;

   assign pulse      = req_tdata[0];
   assign tick       = req_tdata[1];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_GATE_TICKS);

   always_comb begin
      if (csr_paddr[2] == REG_GATE_TICKS) begin
         csr_prdata = CSR_DATA_WIDTH'(gate_ticks_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ticks_ff <= GATE_TICKS_RESET;
      end else if (csr_write) begin
         gate_ticks_ff <= csr_pwdata[COUNT_WIDTH-1:0];
      end
   end

   // pulse counting, binary and decimal side by side so a capture needs no divide
   always_comb begin
      pulse_count_in = pulse_count_ff;
      pulse_bcd_in   = pulse_bcd_ff;
      carry          = 1'b1;
      if (pulse) begin
         pulse_count_in = pulse_count_ff + 1'b1;
         if (pulse_count_ff == '1) begin
            pulse_bcd_in = '0;
         end else begin
            for (int i = 0; i < VALUE_DIGITS; i++) begin
               if (carry) begin
                  if (pulse_bcd_ff[i] == 4'd9) begin
                     pulse_bcd_in[i] = 4'd0;
                  end else begin
                     pulse_bcd_in[i] = pulse_bcd_ff[i] + 4'd1;
                     carry           = 1'b0;
                  end
               end
            end
         end
      end
   end

   // gate, capture, and display scan
   always_comb begin
      tick_count_inc     = tick_count_ff + 1'b1;
      gate_end           = tick && (tick_count_inc == gate_ticks_ff);
      tick_count_in      = tick_count_ff;
      digit_values_in    = digit_values_ff;
      last_frequency_in  = last_frequency_ff;
      scan_position_in   = scan_position_ff;
      segment_pattern_in = DASH_PATTERN;
      digit_enable_in    = 8'(1) << scan_position_ff;
      reading_done_in    = gate_end;

      if (tick) begin
         tick_count_in = tick_count_inc;
         if (scan_position_ff == SCAN_LAST) begin
            scan_position_in = '0;
         end else begin
            scan_position_in = scan_position_ff + 1'b1;
         end
      end

      if (gate_end) begin
         tick_count_in     = '0;
         last_frequency_in = pulse_count_in;
         for (int k = 0; k < VALUE_DIGITS; k++) begin
            digit_values_in[k] = pulse_bcd_in[VALUE_DIGITS-1-k];
         end
      end

      if (32'(scan_position_ff) < 32'(VALUE_DIGITS)) begin
         segment_pattern_in = seg_font(digit_values_in[scan_position_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff    <= '0;
         pulse_bcd_ff      <= '0;
         tick_count_ff     <= '0;
         scan_position_ff  <= '0;
         last_frequency_ff <= '0;
         for (int k = 0; k < VALUE_DIGITS; k++) begin
            digit_values_ff[k] <= 4'(k + 1);
         end
      end else if (req_accept) begin
         if (gate_end) begin
            pulse_count_ff <= '0;
            pulse_bcd_ff   <= '0;
         end else begin
            pulse_count_ff <= pulse_count_in;
            pulse_bcd_ff   <= pulse_bcd_in;
         end
         tick_count_ff     <= tick_count_in;
         scan_position_ff  <= scan_position_in;
         last_frequency_ff <= last_frequency_in;
         digit_values_ff   <= digit_values_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept && tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && tick) begin
         segment_pattern_ff <= segment_pattern_in;
         digit_enable_ff    <= digit_enable_in;
         frequency_ff       <= last_frequency_in;
         reading_done_ff    <= reading_done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {frequency_ff, digit_enable_ff, segment_pattern_ff};
   assign rsp_tuser  = reading_done_ff;

`ifndef NO_ASSERTIONS
   // decimal mirror must always equal the binary pulse count
   a_bcd_tracks_count: assert property (@(posedge clock) disable iff (reset)
      32'(pulse_count_ff) == 32'(pulse_bcd_ff[0]) + 32'(pulse_bcd_ff[1]) * 10
         + 32'(pulse_bcd_ff[2]) * 100 + 32'(pulse_bcd_ff[3]) * 1000
         + 32'(pulse_bcd_ff[4]) * 10000)
      else $error("decimal pulse count out of step with binary count");

   // exactly one display position enabled, and only a configured one
   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[15:8])
         && (32'(rsp_tdata[15:8]) < (32'd1 << DISPLAY_DIGITS)))
      else $error("digit enable not a valid one-hot position");

   // a finished gate leaves the counters cleared
   a_gate_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && gate_end |=> tick_count_ff == '0 && pulse_count_ff == '0)
      else $error("counters not cleared at end of gate");

   // a reported reading carries the frequency that was captured
   a_done_frequency: assert property (@(posedge clock) disable iff (reset)
      req_accept && gate_end |=> rsp_tvalid && rsp_tuser[0]
         && rsp_tdata[31:16] == last_frequency_ff)
      else $error("reading done without matching frequency");
`endif

endmodule

// File: sim/tb_gated_frequency_counter_display_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gated_frequency_counter_display_top: stream driver,
// result monitor with its own frequency/display predictor, APB register accesses.
// Depends on rtl/gfcd_pkg.sv and rtl/gated_frequency_counter_display_top.sv.
module tb_gated_frequency_counter_display_top;
   import gfcd_pkg::*;

   localparam int DIGITS          = DISPLAY_DIGITS_DEFAULT;
   localparam int IDLE_LIMIT      = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [CSR_ADDR_WIDTH-1:0] GATE_TICKS_ADDR = {REG_GATE_TICKS, 2'b00};

   typedef struct packed {
      logic pulse;
      logic tick;
   } edge_item_type;

   typedef struct packed {
      logic [7:0]             segments;
      logic [7:0]             enables;
      logic [COUNT_WIDTH-1:0] frequency;
      logic                   done;
   } display_reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;   // [0] pulse, [1] tick
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;        // [7:0] segments, [15:8] enables, [31:16] frequency
   logic [0:0]                rsp_tuser;        // [0] reading_done
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   gated_frequency_counter_display_top #(.DISPLAY_DIGITS(DIGITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   edge_item_type       pending_edges[$];
   display_reading_type readings_due[$];
   int                  failures = 0;

   // predictor state
   logic [COUNT_WIDTH-1:0] gate_shadow = GATE_TICKS_RESET;
   logic [COUNT_WIDTH-1:0] pulse_tally = '0;
   logic [COUNT_WIDTH-1:0] tick_tally = '0;
   logic [COUNT_WIDTH-1:0] freq_shadow = '0;
   logic [SCAN_WIDTH-1:0]  scan_shadow = '0;
   bcd_digit_type          digit_shadow [VALUE_DIGITS];

   // sender burst shaping, receiver stall shaping
   int          burst_left = 0;
   int          gap_left = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int unsigned stall_clock = 0;
   int          idle_cycles = 0;

   function automatic logic [7:0] glyph_for(input bcd_digit_type d);
      logic [7:0] g;
      case (d)
         4'd0:    g = 8'hc0;
         4'd1:    g = 8'hf9;
         4'd2:    g = 8'ha4;
         4'd3:    g = 8'hb0;
         4'd4:    g = 8'h99;
         4'd5:    g = 8'h92;
         4'd6:    g = 8'h82;
         4'd7:    g = 8'hf8;
         4'd8:    g = 8'h80;
         4'd9:    g = 8'h90;
         default: g = DASH_PATTERN;
      endcase
      return g;
   endfunction

   function automatic void count_edges(input edge_item_type item);
      display_reading_type r;
      int unsigned         pos;
      int unsigned         v;
      if (item.pulse) pulse_tally = pulse_tally + 1'b1;
      if (!item.tick) return;
      tick_tally = tick_tally + 1'b1;
      r.done = 1'b0;
      // pulse of this transfer is already in the tally
      if (tick_tally == gate_shadow) begin
         freq_shadow = pulse_tally;
         v = pulse_tally;
         digit_shadow[0] = 4'(v / 10000);
         digit_shadow[1] = 4'((v % 10000) / 1000);
         digit_shadow[2] = 4'((v % 1000) / 100);
         digit_shadow[3] = 4'((v % 100) / 10);
         digit_shadow[4] = 4'(v % 10);
         pulse_tally = '0;
         tick_tally = '0;
         r.done = 1'b1;
      end
      pos = scan_shadow;
      if (pos >= DIGITS) pos = 0;
      r.segments  = (pos < VALUE_DIGITS) ? glyph_for(digit_shadow[pos]) : DASH_PATTERN;
      r.enables   = 8'(1 << pos);
      r.frequency = freq_shadow;
      readings_due.push_back(r);
      pos = pos + 1;
      if (pos >= DIGITS) pos = 0;
      scan_shadow = SCAN_WIDTH'(pos);
   endfunction

   function automatic void push_edge(input logic pulse, input logic tick);
      edge_item_type item;
      item.pulse = pulse;
      item.tick  = tick;
      pending_edges.push_back(item);
   endfunction

   // driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : drive_edges
      edge_item_type item;
      edge_item_type taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken.pulse = req_tdata[0];
            taken.tick  = req_tdata[1];
            count_edges(taken);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_edges.size() > 0) begin
               item = pending_edges.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, item.tick, item.pulse};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result transfer with the oldest predicted reading
   always @(posedge clock) begin : watch_readings
      display_reading_type got;
      display_reading_type want;
      int                  stall_pct;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.segments  = rsp_tdata[7:0];
            got.enables   = rsp_tdata[15:8];
            got.frequency = rsp_tdata[31:16];
            got.done      = rsp_tuser[0];
            if (readings_due.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("unexpected reading: seg %h en %h freq %0d done %0d",
                           got.segments, got.enables, got.frequency, got.done);
               failures = failures + 1;
            end else begin
               want = readings_due.pop_front();
               if (got !== want) begin
                  if (failures < REPORT_LIMIT)
                     $display("reading mismatch: seg %h/%h en %h/%h freq %0d/%0d done %0d/%0d",
                              want.segments, got.segments, want.enables, got.enables,
                              want.frequency, got.frequency, want.done, got.done);
                  failures = failures + 1;
               end
            end
         end
         stall_clock = stall_clock + 1;
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_clock[9:8])
               2'd0:    stall_pct = 0;
               2'd1:    stall_pct = 15;
               2'd2:    stall_pct = 45;
               default: stall_pct = 75;
            endcase
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (pending_edges.size() != 0 || req_tvalid || readings_due.size() != 0)
         @(posedge clock);
      // a pulse-only transfer may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= GATE_TICKS_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_gate(input logic [COUNT_WIDTH-1:0] ticks);
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_access(1'b1, CSR_DATA_WIDTH'(ticks), rd);
      gate_shadow = ticks;
      csr_access(1'b0, '0, rd);
      if (rd[COUNT_WIDTH-1:0] !== ticks) begin
         if (failures < REPORT_LIMIT)
            $display("gate_ticks readback mismatch: expected %0d got %0d", ticks,
                     rd[COUNT_WIDTH-1:0]);
         failures = failures + 1;
      end
   endtask

   initial begin : stimulus
      int                     tick_pct;
      int                     pulse_pct;
      logic [COUNT_WIDTH-1:0] gate_plan [6];
      for (int i = 0; i < VALUE_DIGITS; i++) digit_shadow[i] = bcd_digit_type'(i + 1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset gate: quiet, pulse-only, tick-only, both, then a full scan plus wrap
      push_edge(1'b0, 1'b0);
      push_edge(1'b1, 1'b0);
      push_edge(1'b0, 1'b1);
      push_edge(1'b1, 1'b1);
      for (int i = 0; i < 7; i++) push_edge(1'b0, 1'b1);
      wait_drained();

      // gate lowered to one above the running tick count: next tick ends it
      set_gate(16'd10);
      push_edge(1'b1, 1'b1);
      wait_drained();

      // one-tick gate: capture on every tick, zero reading included
      set_gate(16'd1);
      push_edge(1'b1, 1'b1);
      push_edge(1'b0, 1'b1);
      push_edge(1'b1, 1'b0);
      push_edge(1'b1, 1'b1);
      wait_drained();

      // gate lowered mid-gate while still above the running tick count
      set_gate(16'd200);
      for (int i = 0; i < 100; i++) push_edge(1'($urandom_range(0, 1)), 1'b1);
      wait_drained();
      set_gate(16'd150);
      for (int i = 0; i < 50; i++) push_edge(1'b1, 1'b1);
      wait_drained();

      gate_plan[0] = 16'd1;
      gate_plan[1] = 16'd2;
      gate_plan[2] = 16'd3;
      gate_plan[3] = 16'($urandom_range(4, 6));
      gate_plan[4] = 16'($urandom_range(7, 12));
      gate_plan[5] = 16'($urandom_range(13, 30));
      for (int p = 0; p < 6; p++) begin
         set_gate(gate_plan[p]);
         tick_pct  = $urandom_range(20, 90);
         pulse_pct = $urandom_range(0, 100);
         for (int i = 0; i < 160; i++)
            push_edge($urandom_range(0, 99) < pulse_pct, $urandom_range(0, 99) < tick_pct);
         // long receiver hold-off while the sender keeps offering
         if (p == 2) hold_requests = hold_requests + 1;
         wait_drained();
      end

      set_gate(GATE_TICKS_RESET);
      for (int i = 0; i < 50; i++)
         push_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      wait_drained();

      repeat (8) @(posedge clock);
      if (readings_due.size() != 0) begin
         $display("%0d readings never arrived", readings_due.size());
         failures = failures + 1;
      end
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/gfcd_pkg.sv
rtl/gated_frequency_counter_display_top.sv
sim/tb_gated_frequency_counter_display_top.sv
